// File: rtl/core/http_response_stream_parser_top_macros.svh
// Assertion macros shared by the HTTP response stream parser RTL.
// Each macro expects clk and rst_n in scope of the including module.
`ifndef HTTP_RESPONSE_STREAM_PARSER_TOP_MACROS_SVH
`define HTTP_RESPONSE_STREAM_PARSER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define HPSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define HPSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/hpsp_pkg.sv
// Package for the HTTP response stream parser: phase and error codes,
// result and per-line state types, and the byte-level matching functions.
// No dependencies.
`timescale 1ns / 1ps

package hpsp_pkg;

  localparam int MAX_LINE_DEF  = 1024;
  localparam int STATUS_OFFSET = 9;
  localparam int VERSION_LEN   = 8;
  localparam int NAME_LEN      = 14;

  localparam logic [2:0] PH_STATUS  = 3'd0;
  localparam logic [2:0] PH_HEADERS = 3'd1;
  localparam logic [2:0] PH_BODY    = 3'd2;
  localparam logic [2:0] PH_DONE    = 3'd3;
  localparam logic [2:0] PH_ERROR   = 3'd4;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_STATUS   = 2'd1;
  localparam logic [1:0] ERR_HEADER   = 2'd2;
  localparam logic [1:0] ERR_TOO_LONG = 2'd3;

  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_COLON = 8'h3a;
  localparam logic [7:0] CHAR_H     = 8'h48;

  typedef struct packed {
    logic [2:0]  phase;
    logic [15:0] http_status;
    logic [15:0] content_length;
    logic        body_valid;
    logic [7:0]  body_byte;
    logic        body_last;
    logic [1:0]  error_code;
    logic        complete;
  } result_t;

  // Matching state that lives for one line and is cleared at its end.
  typedef struct packed {
    logic [3:0]  ver_pos;
    logic [15:0] status_accum;
    logic        status_done;
    logic        colon_seen;
    logic        skipping;
    logic        value_nonempty;
    logic [3:0]  name_pos;
    logic        name_mismatch;
    logic [15:0] value_accum;
    logic        value_done;
  } line_t;

  function automatic logic [7:0] version_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = "H";
      3'd1:    c = "T";
      3'd2:    c = "T";
      3'd3:    c = "P";
      3'd4:    c = "/";
      3'd5:    c = "1";
      3'd6:    c = ".";
      default: c = "1";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] name_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = "C";
      4'd1:    c = "O";
      4'd2:    c = "N";
      4'd3:    c = "T";
      4'd4:    c = "E";
      4'd5:    c = "N";
      4'd6:    c = "T";
      4'd7:    c = "-";
      4'd8:    c = "L";
      4'd9:    c = "E";
      4'd10:   c = "N";
      4'd11:   c = "G";
      4'd12:   c = "T";
      4'd13:   c = "H";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] upcase(input logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0" && c <= "9");
  endfunction

  // acc * 10 + digit, wrapping at 16 bits; shifts and adds only.
  function automatic logic [15:0] dec_step(input logic [15:0] acc, input logic [7:0] c);
    logic [7:0] d;
    d = c - "0";
    return (acc << 3) + (acc << 1) + {12'd0, d[3:0]};
  endfunction

  // Fold one content byte of the current line into the line state.
  function automatic line_t take_content(input line_t s, input logic in_status,
                                         input logic [7:0] c, input logic past_offset);
    line_t n;
    n = s;
    if (in_status) begin
      if (s.ver_pos < 4'(VERSION_LEN)) begin
        if (c == version_char(s.ver_pos[2:0])) n.ver_pos = s.ver_pos + 4'd1;
        else n.ver_pos = (c == CHAR_H) ? 4'd1 : 4'd0;
      end
      if (past_offset && !s.status_done) begin
        if (is_digit(c)) n.status_accum = dec_step(s.status_accum, c);
        else n.status_done = 1'b1;
      end
    end else if (!s.colon_seen) begin
      if (c == CHAR_COLON) begin
        n.colon_seen = 1'b1;
        n.skipping   = 1'b1;
      end else if (!s.name_mismatch && s.name_pos < 4'(NAME_LEN) &&
                   upcase(c) == name_char(s.name_pos)) begin
        n.name_pos = s.name_pos + 4'd1;
      end else begin
        n.name_mismatch = 1'b1;
      end
    end else if (s.skipping && c == CHAR_SPACE) begin
      n = s;
    end else begin
      n.skipping = 1'b0;
      if (s.skipping) n.value_nonempty = 1'b1;
      if (!s.value_done) begin
        if (is_digit(c)) n.value_accum = dec_step(s.value_accum, c);
        else n.value_done = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

// File: rtl/core/hpsp_if.sv
// Valid/ready channel interfaces for the HTTP response stream parser:
// the received-byte channel and the per-byte result channel. Uses hpsp_pkg.
`timescale 1ns / 1ps

interface hpsp_in_if import hpsp_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       start_req;

  modport source (output valid, output rx_byte, output start_req, input ready);
  modport sink (input valid, input rx_byte, input start_req, output ready);
endinterface

interface hpsp_out_if import hpsp_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [2:0]  phase;
  logic [15:0] http_status;
  logic [15:0] content_length;
  logic        body_valid;
  logic [7:0]  body_byte;
  logic        body_last;
  logic [1:0]  error_code;
  logic        complete;

  modport source (output valid, output phase, output http_status, output content_length,
                  output body_valid, output body_byte, output body_last,
                  output error_code, output complete, input ready);
  modport sink (input valid, input phase, input http_status, input content_length,
                input body_valid, input body_byte, input body_last,
                input error_code, input complete, output ready);
endinterface

// File: rtl/core/hpsp_core.sv
// Parse state registers and the per-byte next-state logic of the HTTP
// response stream parser. Depends on hpsp_pkg.
`timescale 1ns / 1ps

module hpsp_core import hpsp_pkg::*; #(
  parameter int MAX_LINE = MAX_LINE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] rx_byte,
  input  logic       start_req,
  output result_t    res
);

  localparam int LCW = $clog2(MAX_LINE + 1);
  localparam logic [LCW:0]   MAXL = (LCW + 1)'(MAX_LINE);
  localparam logic [LCW-1:0] OFFS = LCW'(STATUS_OFFSET);

  logic [2:0]     phase_r, phase_nxt;
  logic [LCW-1:0] count_r, count_nxt;
  logic           pend_r, pend_nxt;
  line_t          line_r, line_nxt;
  logic [15:0]    length_r, length_nxt;
  logic [15:0]    status_r, status_nxt;
  logic [15:0]    body_cnt_r, body_cnt_nxt;
  logic [1:0]     err_r, err_nxt;

  logic [2:0]     ph_c;
  logic [LCW-1:0] cnt_c;
  logic           pend_c;
  line_t          line_c;
  logic [15:0]    len_c, body_c;
  logic [15:0]    body_inc;
  logic           done, bvalid, blast;
  line_t          l1;
  logic [LCW-1:0] cnt1;
  logic           in_status;

  always_comb begin
    // A start byte sees the state as after reset.
    ph_c   = start_req ? PH_STATUS : phase_r;
    cnt_c  = start_req ? '0 : count_r;
    pend_c = start_req ? 1'b0 : pend_r;
    line_c = start_req ? '0 : line_r;
    len_c  = start_req ? '0 : length_r;
    body_c = start_req ? '0 : body_cnt_r;

    phase_nxt    = ph_c;
    count_nxt    = cnt_c;
    pend_nxt     = pend_c;
    line_nxt     = line_c;
    length_nxt   = len_c;
    status_nxt   = start_req ? '0 : status_r;
    body_cnt_nxt = body_c;
    err_nxt      = start_req ? ERR_NONE : err_r;
    done         = 1'b0;
    bvalid       = 1'b0;
    blast        = 1'b0;
    in_status    = (ph_c == PH_STATUS);
    l1           = line_c;
    cnt1         = cnt_c;
    body_inc     = body_c + 16'd1;

    if (ph_c == PH_STATUS || ph_c == PH_HEADERS) begin
      if (pend_c && rx_byte == CHAR_LF) begin
        if (in_status) begin
          if (line_c.ver_pos != 4'(VERSION_LEN)) begin
            phase_nxt = PH_ERROR;
            err_nxt   = ERR_STATUS;
          end else begin
            status_nxt = line_c.status_accum;
            phase_nxt  = PH_HEADERS;
            count_nxt  = '0;
            pend_nxt   = 1'b0;
            line_nxt   = '0;
          end
        end else if (cnt_c == '0) begin
          // Empty line: headers end here.
          count_nxt = '0;
          pend_nxt  = 1'b0;
          line_nxt  = '0;
          if (len_c != 16'd0) begin
            phase_nxt = PH_BODY;
          end else begin
            phase_nxt = PH_DONE;
            done      = 1'b1;
          end
        end else if (!line_c.colon_seen || !line_c.value_nonempty) begin
          phase_nxt = PH_ERROR;
          err_nxt   = ERR_HEADER;
        end else begin
          if (!line_c.name_mismatch && line_c.name_pos == 4'(NAME_LEN)) begin
            length_nxt = line_c.value_accum;
          end
          count_nxt = '0;
          pend_nxt  = 1'b0;
          line_nxt  = '0;
        end
      end else begin
        // A held CR not followed by LF is an ordinary byte of the line.
        if (pend_c) begin
          l1   = take_content(line_c, in_status, CHAR_CR, cnt_c >= OFFS);
          cnt1 = cnt_c + 1'b1;
        end
        if (rx_byte == CHAR_CR) begin
          pend_nxt  = 1'b1;
          line_nxt  = l1;
          count_nxt = cnt1;
        end else begin
          pend_nxt  = 1'b0;
          line_nxt  = take_content(l1, in_status, rx_byte, cnt1 >= OFFS);
          count_nxt = cnt1 + 1'b1;
        end
        if ({1'b0, count_nxt} + {{LCW{1'b0}}, pend_nxt} >= MAXL) begin
          phase_nxt = PH_ERROR;
          err_nxt   = ERR_TOO_LONG;
        end
      end
    end else if (ph_c == PH_BODY) begin
      bvalid       = 1'b1;
      body_cnt_nxt = body_inc;
      if (body_inc == len_c) begin
        blast     = 1'b1;
        done      = 1'b1;
        phase_nxt = PH_DONE;
      end
    end

    res.phase          = phase_nxt;
    res.http_status    = status_nxt;
    res.content_length = length_nxt;
    res.body_valid     = bvalid;
    res.body_byte      = bvalid ? rx_byte : 8'd0;
    res.body_last      = blast;
    res.error_code     = err_nxt;
    res.complete       = done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_STATUS;
      count_r    <= '0;
      pend_r     <= 1'b0;
      line_r     <= '0;
      length_r   <= '0;
      status_r   <= '0;
      body_cnt_r <= '0;
      err_r      <= ERR_NONE;
    end else if (take) begin
      phase_r    <= phase_nxt;
      count_r    <= count_nxt;
      pend_r     <= pend_nxt;
      line_r     <= line_nxt;
      length_r   <= length_nxt;
      status_r   <= status_nxt;
      body_cnt_r <= body_cnt_nxt;
      err_r      <= err_nxt;
    end
  end

endmodule

// File: rtl/core/http_response_stream_parser_top.sv
// HTTP/1.1 response stream parser, one received byte per item, one result per item.
// Top level: handshake and result register around hpsp_core. Depends on hpsp_pkg,
// hpsp_if.sv and http_response_stream_parser_top_macros.svh.
`timescale 1ns / 1ps

// Feed the response byte by byte on in_ch; raise start_req on the first byte
// of every response to clear all parse state. Each accepted item yields
// exactly one result item on out_ch, on the next cycle: the phase after the
// byte, the status code and Content-Length seen so far, a body byte strobe
// with a last-byte marker, the held error code and a completion pulse. The
// block takes one byte every cycle; the parse state is updated in the same
// cycle the byte is accepted, and a single result register decouples the
// two sides, so in_ch stalls only while that register is full and out_ch
// is not ready. After completion or an error, bytes are still accepted and
// answered, but change nothing until the next start_req. MAX_LINE bounds
// the bytes of one line, including a trailing CR still waiting for its LF.

`include "http_response_stream_parser_top_macros.svh"

module http_response_stream_parser_top import hpsp_pkg::*; #(
  parameter int MAX_LINE = MAX_LINE_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  hpsp_in_if.sink    in_ch,
  hpsp_out_if.source out_ch
);

  logic    take;
  result_t core_res;
  result_t res_r;
  logic    out_vld_r;

  // Accept whenever the result register is empty or is being drained.
  assign in_ch.ready = !out_vld_r || out_ch.ready;
  assign take        = in_ch.valid && in_ch.ready;

  hpsp_core #(
    .MAX_LINE (MAX_LINE)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .rx_byte   (in_ch.rx_byte),
    .start_req (in_ch.start_req),
    .res       (core_res)
  );

  // Hold the result until taken; load a fresh one on every accepted byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (take) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= core_res;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.phase          = res_r.phase;
  assign out_ch.http_status    = res_r.http_status;
  assign out_ch.content_length = res_r.content_length;
  assign out_ch.body_valid     = res_r.body_valid;
  assign out_ch.body_byte      = res_r.body_byte;
  assign out_ch.body_last      = res_r.body_last;
  assign out_ch.error_code     = res_r.error_code;
  assign out_ch.complete       = res_r.complete;

  // The last body byte always finishes the response.
  `HPSP_ASSERT_NOW(a_last_completes, out_vld_r && res_r.body_last,
                   res_r.body_valid && res_r.complete && res_r.phase == PH_DONE,
                   "body_last without completion")

  // An error code is shown exactly while the phase is error.
  `HPSP_ASSERT_NOW(a_err_phase, out_vld_r,
                   (res_r.phase == PH_ERROR) == (res_r.error_code != ERR_NONE),
                   "error code and phase disagree")

  // Completion is only reported together with the done phase.
  `HPSP_ASSERT_NOW(a_complete_phase, out_vld_r && res_r.complete, res_r.phase == PH_DONE,
                   "complete outside done phase")

  // The first byte of a response always leaves the parser in the status line.
  `HPSP_ASSERT_NEXT(a_start_status, take && in_ch.start_req,
                    out_vld_r && res_r.phase == PH_STATUS && res_r.http_status == 16'd0,
                    "start byte left status line")

endmodule
